// ----- sv/opr_pkg.sv -----
// Constants, types and helpers for the optics polynomial reconstruction block.
package opr_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int POLY_TERMS  = 7;
    localparam int MAX_POWER   = 10;
    localparam int NTAB        = 4;
    localparam int NVAR        = 3;

    localparam int QW         = 48;
    localparam int LIMB       = QW / 2;
    localparam int EI_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int PW_W       = $clog2(MAX_POWER);
    localparam int CI_W       = $clog2(POLY_TERMS);
    localparam int TERM_W     = 9;
    localparam int COEF_DEPTH = NTAB * MAX_ENTRIES * POLY_TERMS;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int POW_DEPTH  = NTAB * MAX_ENTRIES;
    localparam int PA_W       = $clog2(POW_DEPTH);
    localparam int ACC_W      = QW + EI_W + 1;
    localparam int PROD_W     = 2 * QW;
    localparam int PADDR_W    = $clog2(NTAB * 4);

    localparam logic [QW-1:0] QMAX    = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] QMIN    = {1'b1, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] ONE_Q24 = QW'(1) << 24;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [1:0] REG_DELTA_TERMS = 2'd0;
    localparam logic [1:0] REG_THETA_TERMS = 2'd1;
    localparam logic [1:0] REG_Y_TERMS     = 2'd2;
    localparam logic [1:0] REG_PHI_TERMS   = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POW,
        ST_TBL,
        ST_WAIT,
        ST_HADD,
        ST_TERM,
        ST_ACC,
        ST_TDONE,
        ST_DONE,
        ST_MUL,
        ST_RND
    } state_t;

    typedef enum logic [1:0] {
        MOP_POW,
        MOP_HORN,
        MOP_TERM
    } mop_t;

    function automatic logic [QW-1:0] mag48(input logic [QW-1:0] a);
        return a[QW-1] ? (~a + QW'(1)) : a;
    endfunction

    function automatic logic clamp_ovf(input logic signed [ACC_W-1:0] a);
        return (a > $signed({{(ACC_W-QW){1'b0}}, QMAX})) ||
               (a < $signed({{(ACC_W-QW){1'b1}}, QMIN}));
    endfunction

    function automatic logic [QW-1:0] clamp_val(input logic signed [ACC_W-1:0] a);
        logic [QW-1:0] r;
        if (a > $signed({{(ACC_W-QW){1'b0}}, QMAX}))
            r = QMAX;
        else if (a < $signed({{(ACC_W-QW){1'b1}}, QMIN}))
            r = QMIN;
        else
            r = a[QW-1:0];
        return r;
    endfunction

endpackage

// ----- sv/optics_polynomial_reconstruct.sv -----
// Optics polynomial reconstruction: table loader and sequenced evaluator.
//
// Input channel (in_valid/in_ready) carries one word per handshake. With
// func = load, the word writes one coefficient and the entry's exponents
// in the cycle it is taken and gives no result; a coef_index past the
// polynomial is ignored. With func = evaluate, the block walks the four
// tables and returns one result word on out_valid/out_ready. The term
// counts are set over the APB port; pready is always high. All products
// run through one shared multiplier taking one 24x24 partial product per
// cycle: a product takes a setup state, four partial products and one
// round/saturate step. An evaluate word first builds the powers of each
// variable up to MAX_POWER-1, then walks each table entry by entry: a
// coefficient fetch, six Horner and three exponent products, a last add
// and an accumulate per entry; finally the output register is loaded.
// in_ready is low for the whole evaluation; the next word is taken once
// the result is in the output register, even while that result is
// still stalled. After reset the coefficient and exponent memories are
// zeroed, one address per cycle across the whole coefficient memory,
// with in_ready low; register writes are taken meanwhile. A stalled
// result holds the finished sums back.
module optics_polynomial_reconstruct
    import opr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [1:0]          table_sel,
    input  logic [7:0]          entry_index,
    input  logic [3:0]          pow_theta,
    input  logic [3:0]          pow_y,
    input  logic [3:0]          pow_phi,
    input  logic [2:0]          coef_index,
    input  logic signed [47:0]  coef_value,
    input  logic signed [31:0]  focal_x,
    input  logic signed [31:0]  focal_tan_theta,
    input  logic signed [31:0]  focal_y,
    input  logic signed [31:0]  focal_tan_phi,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [47:0]  target_delta,
    output logic signed [47:0]  target_tan_theta,
    output logic signed [47:0]  target_y,
    output logic signed [47:0]  target_tan_phi,
    output logic                overflow,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // control
    state_t              state_reg, state_next;
    mop_t                mop_reg, mop_next;
    logic [CA_W-1:0]     clr_reg, clr_next;
    logic [1:0]          tbl_reg, tbl_next;
    logic [CNT_W-1:0]    ent_reg, ent_next;
    logic [CI_W-1:0]     ci_reg, ci_next;
    logic [1:0]          dvar_reg, dvar_next;
    logic [PW_W-1:0]     kpow_reg, kpow_next;
    logic [1:0]          pp_reg, pp_next;
    logic                out_valid_reg, out_valid_next;
    logic                flag_reg, flag_next;
    logic [TERM_W-1:0]   terms_reg [NTAB];

    // datapath
    logic [QW-1:0]       fx_reg, fx_next;
    logic [QW-1:0]       fv_reg [NVAR];
    logic [QW-1:0]       fv_next [NVAR];
    logic [QW-1:0]       pw_reg [NVAR][MAX_POWER];
    logic [QW-1:0]       pw_next [NVAR][MAX_POWER];
    logic                pf_reg [NVAR][MAX_POWER];
    logic                pf_next [NVAR][MAX_POWER];
    logic [QW-1:0]       v_reg, v_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [QW-1:0]       ma_reg, ma_next;
    logic [QW-1:0]       mb_reg, mb_next;
    logic                neg_reg, neg_next;
    logic                sh28_reg, sh28_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [QW-1:0]       res_reg [NTAB];
    logic [QW-1:0]       res_next [NTAB];
    logic [QW-1:0]       out_reg [NTAB];
    logic [QW-1:0]       out_next [NTAB];
    logic                ovf_reg, ovf_next;

    // memories
    logic [QW-1:0]       coef_mem [COEF_DEPTH];
    logic [11:0]         power_mem [POW_DEPTH];
    logic [QW-1:0]       coef_q_reg;
    logic [11:0]         power_q_reg;
    logic                cwe, pwe;
    logic [CA_W-1:0]     cwaddr, craddr;
    logic [PA_W-1:0]     pwaddr, praddr;
    logic [QW-1:0]       cwdata;
    logic [11:0]         pwdata_mem;

    // combinational temporaries
    logic [LIMB-1:0]     a_part, b_part;
    logic [2*LIMB-1:0]   part;
    logic [PROD_W-1:0]   part_sh;
    logic [PROD_W:0]     rsum, rq, rlim;
    logic                mul_ovf;
    logic [QW-1:0]       rmag, mul_res;
    logic [CNT_W-1:0]    n_eff;
    logic [ACC_W-1:0]    hsum;
    logic [QW-1:0]       hval;
    logic [3:0]          exf;
    logic [PW_W-1:0]     ex;
    logic                cfg_wr;

    assign praddr = {tbl_reg, ent_reg[EI_W-1:0]};
    assign craddr = CA_W'({tbl_reg, ent_reg[EI_W-1:0]}) * CA_W'(POLY_TERMS) + CA_W'(ci_reg);

    always_ff @(posedge clk)
    begin
        if (cwe)
            coef_mem[cwaddr] <= cwdata;
        coef_q_reg <= coef_mem[craddr];
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
            power_mem[pwaddr] <= pwdata_mem;
        power_q_reg <= power_mem[praddr];
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NTAB; i++)
                terms_reg[i] <= '0;
        end
        else if (cfg_wr)
        begin
            terms_reg[paddr[PADDR_W-1:2]] <= pwdata[TERM_W-1:0];
        end
    end

    always_comb
    begin
        case (paddr[PADDR_W-1:2])
            REG_DELTA_TERMS: prdata = 32'(terms_reg[0]);
            REG_THETA_TERMS: prdata = 32'(terms_reg[1]);
            REG_Y_TERMS:     prdata = 32'(terms_reg[2]);
            REG_PHI_TERMS:   prdata = 32'(terms_reg[3]);
            default:         prdata = '0;
        endcase
    end

    // shared multiplier datapath
    always_comb
    begin
        a_part = pp_reg[0] ? ma_reg[QW-1:LIMB] : ma_reg[LIMB-1:0];
        b_part = pp_reg[1] ? mb_reg[QW-1:LIMB] : mb_reg[LIMB-1:0];
        part   = a_part * b_part;
        case (pp_reg)
            2'd0:    part_sh = PROD_W'(part);
            2'd3:    part_sh = PROD_W'(part) << (2 * LIMB);
            default: part_sh = PROD_W'(part) << LIMB;
        endcase
        rsum = {1'b0, prod_reg} + (sh28_reg ? ((PROD_W+1)'(1) << 27)
                                            : ((PROD_W+1)'(1) << 23));
        rq   = sh28_reg ? (rsum >> 28) : (rsum >> 24);
        rlim = neg_reg ? ((PROD_W+1)'(1) << (QW-1)) : (PROD_W+1)'(QMAX);
        mul_ovf = rq > rlim;
        rmag    = mul_ovf ? rlim[QW-1:0] : rq[QW-1:0];
        mul_res = neg_reg ? (~rmag + QW'(1)) : rmag;
    end

    always_comb
    begin
        state_next     = state_reg;
        mop_next       = mop_reg;
        clr_next       = clr_reg;
        tbl_next       = tbl_reg;
        ent_next       = ent_reg;
        ci_next        = ci_reg;
        dvar_next      = dvar_reg;
        kpow_next      = kpow_reg;
        pp_next        = pp_reg;
        out_valid_next = out_valid_reg;
        flag_next      = flag_reg;
        fx_next        = fx_reg;
        fv_next        = fv_reg;
        pw_next        = pw_reg;
        pf_next        = pf_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        neg_next       = neg_reg;
        sh28_next      = sh28_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ovf_next       = ovf_reg;
        cwe            = 1'b0;
        pwe            = 1'b0;
        cwaddr         = clr_reg;
        pwaddr         = clr_reg[PA_W-1:0];
        cwdata         = '0;
        pwdata_mem     = '0;
        in_ready       = (state_reg == ST_IDLE);

        n_eff = (terms_reg[tbl_reg] > TERM_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                             : CNT_W'(terms_reg[tbl_reg]);
        hsum  = ACC_W'($signed(v_reg)) + ACC_W'($signed(coef_q_reg));
        hval  = clamp_val(hsum);
        exf   = power_q_reg[{dvar_reg, 2'b00} +: 4];
        ex    = (exf >= 4'(MAX_POWER)) ? PW_W'(MAX_POWER - 1) : PW_W'(exf);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                cwe = 1'b1;
                pwe = (32'(clr_reg) < POW_DEPTH);
                if (clr_reg == CA_W'(COEF_DEPTH - 1))
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + CA_W'(1);
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        if ((32'(entry_index) < MAX_ENTRIES) &&
                            (32'(coef_index) < POLY_TERMS))
                        begin
                            cwe        = 1'b1;
                            pwe        = 1'b1;
                            pwaddr     = {table_sel, entry_index[EI_W-1:0]};
                            cwaddr     = CA_W'({table_sel, entry_index[EI_W-1:0]})
                                         * CA_W'(POLY_TERMS) + CA_W'(coef_index);
                            cwdata     = coef_value;
                            pwdata_mem = {pow_phi, pow_y, pow_theta};
                        end
                    end
                    else
                    begin
                        fx_next    = QW'(focal_x);
                        fv_next[0] = QW'(focal_tan_theta);
                        fv_next[1] = QW'(focal_y);
                        fv_next[2] = QW'(focal_tan_phi);
                        for (int d = 0; d < NVAR; d++)
                        begin
                            pw_next[d][0] = ONE_Q24;
                            pf_next[d][0] = 1'b0;
                        end
                        dvar_next  = '0;
                        kpow_next  = PW_W'(1);
                        flag_next  = 1'b0;
                        state_next = ST_POW;
                    end
                end
            end
            ST_POW:
            begin
                ma_next    = mag48(pw_reg[dvar_reg][kpow_reg - PW_W'(1)]);
                mb_next    = mag48(fv_reg[dvar_reg]);
                neg_next   = pw_reg[dvar_reg][kpow_reg - PW_W'(1)][QW-1]
                             ^ fv_reg[dvar_reg][QW-1];
                sh28_next  = 1'b1;
                prod_next  = '0;
                pp_next    = '0;
                mop_next   = MOP_POW;
                state_next = ST_MUL;
            end
            ST_TBL:
            begin
                acc_next = '0;
                ent_next = '0;
                ci_next  = CI_W'(POLY_TERMS - 1);
                v_next   = '0;
                if (n_eff == '0)
                    state_next = ST_TDONE;
                else
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                // coefficient read settles
                state_next = ST_HADD;
            end
            ST_HADD:
            begin
                flag_next = flag_reg | clamp_ovf(hsum);
                if (ci_reg != '0)
                begin
                    ma_next    = mag48(hval);
                    mb_next    = mag48(fx_reg);
                    neg_next   = hval[QW-1] ^ fx_reg[QW-1];
                    sh28_next  = 1'b1;
                    prod_next  = '0;
                    pp_next    = '0;
                    ci_next    = ci_reg - CI_W'(1);
                    mop_next   = MOP_HORN;
                    state_next = ST_MUL;
                end
                else
                begin
                    v_next     = hval;
                    dvar_next  = '0;
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                flag_next  = flag_reg | pf_reg[dvar_reg][ex];
                ma_next    = mag48(v_reg);
                mb_next    = mag48(pw_reg[dvar_reg][ex]);
                neg_next   = v_reg[QW-1] ^ pw_reg[dvar_reg][ex][QW-1];
                sh28_next  = 1'b0;
                prod_next  = '0;
                pp_next    = '0;
                mop_next   = MOP_TERM;
                state_next = ST_MUL;
            end
            ST_ACC:
            begin
                acc_next = acc_reg + ACC_W'($signed(v_reg));
                ent_next = ent_reg + CNT_W'(1);
                ci_next  = CI_W'(POLY_TERMS - 1);
                v_next   = '0;
                if (ent_reg + CNT_W'(1) == n_eff)
                    state_next = ST_TDONE;
                else
                    state_next = ST_WAIT;
            end
            ST_TDONE:
            begin
                res_next[tbl_reg] = clamp_val(acc_reg);
                flag_next         = flag_reg | clamp_ovf(acc_reg);
                if (tbl_reg == 2'(NTAB - 1))
                    state_next = ST_DONE;
                else
                begin
                    tbl_next   = tbl_reg + 2'd1;
                    state_next = ST_TBL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    ovf_next       = flag_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                prod_next = prod_reg + part_sh;
                pp_next   = pp_reg + 2'd1;
                if (pp_reg == 2'd3)
                    state_next = ST_RND;
            end
            ST_RND:
            begin
                case (mop_reg)
                    MOP_POW:
                    begin
                        pw_next[dvar_reg][kpow_reg] = mul_res;
                        pf_next[dvar_reg][kpow_reg] =
                            pf_reg[dvar_reg][kpow_reg - PW_W'(1)] | mul_ovf;
                        if (kpow_reg == PW_W'(MAX_POWER - 1))
                        begin
                            kpow_next = PW_W'(1);
                            if (dvar_reg == 2'(NVAR - 1))
                            begin
                                tbl_next   = '0;
                                state_next = ST_TBL;
                            end
                            else
                            begin
                                dvar_next  = dvar_reg + 2'd1;
                                state_next = ST_POW;
                            end
                        end
                        else
                        begin
                            kpow_next  = kpow_reg + PW_W'(1);
                            state_next = ST_POW;
                        end
                    end
                    MOP_HORN:
                    begin
                        v_next     = mul_res;
                        flag_next  = flag_reg | mul_ovf;
                        state_next = ST_HADD;
                    end
                    MOP_TERM:
                    begin
                        v_next    = mul_res;
                        flag_next = flag_reg | mul_ovf;
                        if (dvar_reg == 2'(NVAR - 1))
                            state_next = ST_ACC;
                        else
                        begin
                            dvar_next  = dvar_reg + 2'd1;
                            state_next = ST_TERM;
                        end
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mop_reg       <= MOP_POW;
            clr_reg       <= '0;
            tbl_reg       <= '0;
            ent_reg       <= '0;
            ci_reg        <= '0;
            dvar_reg      <= '0;
            kpow_reg      <= '0;
            pp_reg        <= '0;
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mop_reg       <= mop_next;
            clr_reg       <= clr_next;
            tbl_reg       <= tbl_next;
            ent_reg       <= ent_next;
            ci_reg        <= ci_next;
            dvar_reg      <= dvar_next;
            kpow_reg      <= kpow_next;
            pp_reg        <= pp_next;
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg   <= fx_next;
        fv_reg   <= fv_next;
        pw_reg   <= pw_next;
        pf_reg   <= pf_next;
        v_reg    <= v_next;
        acc_reg  <= acc_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        sh28_reg <= sh28_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        ovf_reg  <= ovf_next;
    end

    assign out_valid        = out_valid_reg;
    assign target_delta     = out_reg[0];
    assign target_tan_theta = out_reg[1];
    assign target_y         = out_reg[2];
    assign target_tan_phi   = out_reg[3];
    assign overflow         = ovf_reg;

`ifndef SYNTHESIS
    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && pp_reg == 2'd3) |=> (state_reg == ST_RND))
        else $error("multiplier did not finish after four partial products");

    a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == FUNC_EVAL) |=> (state_reg == ST_POW))
        else $error("evaluate word did not start power build");

    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside completion");

    a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(ent_reg) <= MAX_ENTRIES))
        else $error("entry counter beyond table depth");
`endif

endmodule

// ----- test/opr_checker.sv -----
// Checker for the optics polynomial block: mirrors tables and registers, predicts sums, compares.
`timescale 1ns / 100ps
module opr_checker
    import opr_pkg::*;
(
    input  logic               clk,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               func,
    input  logic [1:0]         table_sel,
    input  logic [7:0]         entry_index,
    input  logic [3:0]         pow_theta,
    input  logic [3:0]         pow_y,
    input  logic [3:0]         pow_phi,
    input  logic [2:0]         coef_index,
    input  logic signed [47:0] coef_value,
    input  logic signed [31:0] focal_x,
    input  logic signed [31:0] focal_tan_theta,
    input  logic signed [31:0] focal_y,
    input  logic signed [31:0] focal_tan_phi,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [47:0] target_delta,
    input  logic signed [47:0] target_tan_theta,
    input  logic signed [47:0] target_y,
    input  logic signed [47:0] target_tan_phi,
    input  logic               overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic [47:0] sum [NTAB];
        logic        ovf;
    } target_word_t;

    localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint SAT_LO = -64'sh8000_0000_0000;

    longint       coef_mem [COEF_DEPTH];
    logic [11:0]  exp_mem [POW_DEPTH];
    logic [8:0]   term_count [NTAB];
    target_word_t target_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
        foreach (coef_mem[i]) coef_mem[i] = 0;
        foreach (exp_mem[i]) exp_mem[i] = '0;
        foreach (term_count[i]) term_count[i] = '0;
    end

    function automatic longint sat48(input longint v, inout bit flag);
        if (v > SAT_HI)
        begin
            flag = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            flag = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // rounded fixed-point multiply, ties away from zero, saturating
    function automatic longint fx_mul(input longint a, input longint b, input int s,
                                      inout bit flag);
        bit          neg;
        logic [95:0] ua, ub, p, q, limit;
        neg   = (a < 0) != (b < 0);
        ua    = 96'(a < 0 ? -a : a);
        ub    = 96'(b < 0 ? -b : b);
        p     = ua * ub;
        q     = (p + (96'd1 << (s - 1))) >> s;
        limit = neg ? (96'd1 << 47) : ((96'd1 << 47) - 1);
        if (q > limit)
        begin
            flag = 1'b1;
            return neg ? SAT_LO : SAT_HI;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic target_word_t predict_targets(input longint x, input longint th,
                                                     input longint yy, input longint ph);
        target_word_t r;
        longint       pw [NVAR][MAX_POWER];
        bit           pf [NVAR][MAX_POWER];
        longint       var_in [NVAR];
        longint       v, acc;
        bit           flag, f;
        int           n, base, ex;
        logic [11:0]  packed_exp;
        flag = 1'b0;
        var_in[0] = th;
        var_in[1] = yy;
        var_in[2] = ph;
        for (int d = 0; d < NVAR; d++)
        begin
            pw[d][0] = 64'sd1 << 24;
            pf[d][0] = 1'b0;
            for (int k = 1; k < MAX_POWER; k++)
            begin
                f = 1'b0;
                pw[d][k] = fx_mul(pw[d][k-1], var_in[d], 28, f);
                pf[d][k] = pf[d][k-1] || f;
            end
        end
        for (int t = 0; t < NTAB; t++)
        begin
            n   = (term_count[t] > MAX_ENTRIES) ? MAX_ENTRIES : int'(term_count[t]);
            acc = 0;
            for (int e = 0; e < n; e++)
            begin
                base       = (t * MAX_ENTRIES + e) * POLY_TERMS;
                packed_exp = exp_mem[t * MAX_ENTRIES + e];
                v = 0;
                for (int i = POLY_TERMS - 1; i >= 1; i--)
                    v = fx_mul(sat48(v + coef_mem[base + i], flag), x, 28, flag);
                v = sat48(v + coef_mem[base], flag);
                for (int d = 0; d < NVAR; d++)
                begin
                    ex = int'(packed_exp[4*d +: 4]);
                    if (ex >= MAX_POWER)
                        ex = MAX_POWER - 1;
                    if (pf[d][ex])
                        flag = 1'b1;
                    v = fx_mul(v, pw[d][ex], 24, flag);
                end
                acc += v;
            end
            r.sum[t] = 48'(sat48(acc, flag));
        end
        r.ovf = flag;
        return r;
    endfunction

    always @(posedge clk)
    begin
        target_word_t exp_w;
        logic [47:0]  got [NTAB];
        int           idx;
        if (psel && penable && pwrite && pready && (paddr >> 2) < NTAB)
            term_count[paddr >> 2] <= pwdata[8:0];
        if (in_valid && in_ready)
        begin
            if (func == FUNC_EVAL)
            begin
                exp_w = predict_targets(longint'(focal_x), longint'(focal_tan_theta),
                                        longint'(focal_y), longint'(focal_tan_phi));
                target_q = {target_q, exp_w};
            end
            else if (coef_index < POLY_TERMS)
            begin
                idx = int'(table_sel) * MAX_ENTRIES + int'(entry_index);
                exp_mem[idx] = {pow_phi, pow_y, pow_theta};
                coef_mem[idx * POLY_TERMS + int'(coef_index)] = longint'(coef_value);
            end
        end
        if (out_valid && out_ready)
        begin
            if (target_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, delta %h", $time, target_delta);
            end
            else
            begin
                exp_w  = target_q.pop_front();
                got[0] = target_delta;
                got[1] = target_tan_theta;
                got[2] = target_y;
                got[3] = target_tan_phi;
                for (int t = 0; t < NTAB; t++)
                begin
                    if (got[t] !== exp_w.sum[t])
                    begin
                        errors++;
                        $display("%0t: table %0d sum expected %h got %h",
                                 $time, t, exp_w.sum[t], got[t]);
                    end
                end
                if (overflow !== exp_w.ovf)
                begin
                    errors++;
                    $display("%0t: overflow expected %b got %b", $time, exp_w.ovf, overflow);
                end
            end
        end
        pending = target_q.size();
    end

endmodule

// ----- test/tb_optics_polynomial_reconstruct.sv -----
// Top-level testbench for the optics polynomial block: stimulus, register setup, verdict.
`timescale 1ns / 100ps
module tb_optics_polynomial_reconstruct;
    import opr_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = FUNC_LOAD;
    logic [1:0]         table_sel = '0;
    logic [7:0]         entry_index = '0;
    logic [3:0]         pow_theta = '0;
    logic [3:0]         pow_y = '0;
    logic [3:0]         pow_phi = '0;
    logic [2:0]         coef_index = '0;
    logic signed [47:0] coef_value = '0;
    logic signed [31:0] focal_x = '0;
    logic signed [31:0] focal_tan_theta = '0;
    logic signed [31:0] focal_y = '0;
    logic signed [31:0] focal_tan_phi = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [47:0] target_delta, target_tan_theta, target_y, target_tan_phi;
    logic               overflow;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int errors, pending;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int live_terms [NTAB];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    optics_polynomial_reconstruct dut (.*);

    opr_checker chk (.*);

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #60ms;
        $display("tb_optics_polynomial_reconstruct NOT OK");
        $finish;
    end

    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_accept();
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_load(input logic [1:0] sel, input logic [7:0] ent,
                             input logic [3:0] pt, input logic [3:0] py,
                             input logic [3:0] pp, input logic [2:0] ci,
                             input logic [47:0] val);
        sender_gap();
        in_valid    <= 1'b1;
        func        <= FUNC_LOAD;
        table_sel   <= sel;
        entry_index <= ent;
        pow_theta   <= pt;
        pow_y       <= py;
        pow_phi     <= pp;
        coef_index  <= ci;
        coef_value  <= val;
        focal_x     <= $urandom;
        wait_accept();
    endtask

    task automatic send_eval(input logic [31:0] x, input logic [31:0] th,
                             input logic [31:0] yy, input logic [31:0] ph);
        sender_gap();
        in_valid        <= 1'b1;
        func            <= FUNC_EVAL;
        table_sel       <= 2'($urandom);
        coef_index      <= 3'($urandom);
        focal_x         <= x;
        focal_tan_theta <= th;
        focal_y         <= yy;
        focal_tan_phi   <= ph;
        wait_accept();
    endtask

    // block idle: wait until every result is in, then add slack
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(reg_idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        live_terms[reg_idx] = (val[8:0] > MAX_ENTRIES) ? MAX_ENTRIES : int'(val[8:0]);
    endtask

    task automatic set_terms(input int d, input int t, input int yy, input int p);
        apb_write(REG_DELTA_TERMS, d);
        apb_write(REG_THETA_TERMS, t);
        apb_write(REG_Y_TERMS, yy);
        apb_write(REG_PHI_TERMS, p);
    endtask

    function automatic logic [47:0] rand_coef();
        if ($urandom_range(9) == 0)
            return {16'($urandom), $urandom};
        return 48'(longint'($urandom_range(0, 1 << 26)) - (64'sd1 << 25));
    endfunction

    function automatic logic [31:0] rand_focal();
        if ($urandom_range(7) == 0)
            return $urandom;
        return 32'(longint'($urandom_range(0, 1 << 29)) - (64'sd1 << 28));
    endfunction

    task automatic random_items(input int count);
        logic [1:0] sel;
        int         lim;
        for (int n = 0; n < count; n++)
        begin
            sel = 2'($urandom);
            lim = live_terms[sel];
            if ($urandom_range(4) == 0)
                send_eval(rand_focal(), rand_focal(), rand_focal(), rand_focal());
            else if (lim > 0 && $urandom_range(9) < 8)
                send_load(sel, 8'($urandom_range(lim - 1)), 4'($urandom_range(0, 3)),
                          4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
                          3'($urandom_range(POLY_TERMS - 1)), rand_coef());
            else
                send_load(sel, 8'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                          3'($urandom), {16'($urandom), $urandom});
        end
        send_eval(rand_focal(), rand_focal(), rand_focal(), rand_focal());
    endtask

    initial
    begin
        foreach (live_terms[i]) live_terms[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: empty tables give zero sums
        send_eval(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1000_0000);
        drain();
        set_terms(2, 2, 1, 1);

        send_load(2'd0, 8'd0, 4'd0, 4'd0, 4'd0, 3'd0, 48'sd1 << 24);
        send_load(2'd0, 8'd1, 4'd15, 4'd9, 4'd10, 3'd6, 48'h7FFF_FFFF_FFFF);
        send_load(2'd1, 8'd0, 4'd1, 4'd2, 4'd3, 3'd0, 48'h8000_0000_0000);
        send_load(2'd1, 8'd1, 4'd0, 4'd0, 4'd0, 3'd3, 48'hFFFF_FFFF_FFFF);
        send_load(2'd2, 8'd0, 4'd0, 4'd1, 4'd0, 3'd1, 48'sd3 << 23);
        // coefficient index past the polynomial: ignored
        send_load(2'd2, 8'd0, 4'd15, 4'd15, 4'd15, 3'd7, 48'h7FFF_FFFF_FFFF);
        send_load(2'd3, 8'd0, 4'd0, 4'd0, 4'd9, 3'd2, 48'sd1 << 24);
        send_load(2'd3, 8'd200, 4'd15, 4'd15, 4'd15, 3'd5, 48'h1234_5678_9ABC);
        send_eval(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000);
        send_eval(32'h0, 32'h0, 32'h0, 32'h0);
        send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_eval(32'hF000_0000, 32'h2000_0000, 32'hE000_0000, 32'h0800_0000);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 59 : (ph == 3) ? 22 : 0;
            stall_pct     = (ph == 2) ? 59 : (ph == 3) ? 22 : 0;
            set_terms($urandom_range(1, 6), $urandom_range(0, 6),
                      $urandom_range(1, 6), $urandom_range(0, 6));
            random_items(20);
            drain();
        end

        // count above the table size acts as the full table
        send_idle_pct = 22;
        stall_pct     = 22;
        set_terms(511, 256, 0, 300);
        send_load(2'd0, 8'd255, 4'd1, 4'd1, 4'd1, 3'd0, 48'sd1 << 24);
        send_load(2'd3, 8'd255, 4'd0, 4'd0, 4'd0, 3'd4, 48'sd5 << 22);
        send_eval(rand_focal(), rand_focal(), rand_focal(), rand_focal());
        drain();

        if (errors == 0 && pending == 0)
            $display("tb_optics_polynomial_reconstruct OK");
        else
            $display("tb_optics_polynomial_reconstruct NOT OK");
        $finish;
    end

endmodule

// ----- optics_polynomial_reconstruct.f -----
sv/opr_pkg.sv
sv/optics_polynomial_reconstruct.sv
test/opr_checker.sv
test/tb_optics_polynomial_reconstruct.sv
